// ===== design/hams_pkg.sv =====
package hams_pkg;

	localparam int unsigned TickW = 17;
	localparam int unsigned PhaseTickW = 16;
	localparam int unsigned SumW = 24;
	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [6:0] FwdSpeedRst = 7'd25;
	localparam logic signed [7:0] RevSpeedRst = 8'sd75;
	localparam logic [15:0] RevMsRst = 16'd250;
	localparam logic [15:0] SampleMsRst = 16'd250;
	localparam logic [15:0] IntervalMsRst = 16'd5000;
	localparam logic [8:0] StallDegRst = 9'd14;

	typedef enum logic [CfgIndexW-1:0] {
		REG_FORWARD_SPEED = 3'd0,
		REG_REVERSE_SPEED = 3'd1,
		REG_REVERSE_MS    = 3'd2,
		REG_SAMPLE_MS     = 3'd3,
		REG_INTERVAL_MS   = 3'd4,
		REG_STALL_DEGREES = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_WINDOW = 4'b0010,
		PH_JAMREV = 4'b0100,
		PH_PERREV = 4'b1000
	} phase_t;

	typedef struct packed {
		logic              operation;
		logic [15:0]       run_time_ms;
		logic signed [7:0] encoder_step;
	} in_beat_t;

	typedef struct packed {
		logic signed [7:0] motor_drive;
		logic              busy_res;
		logic              finished;
		logic              jam_seen;
	} out_beat_t;

endpackage

// ===== design/hopper_antijam_motor_sequencer_unit.sv =====
// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall  | in_data  (hams_pkg::in_beat_t)
// out     | out of    | out_valid / out_stall| out_data (hams_pkg::out_beat_t)
// cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted beat lands in the input register,
// and its result is computed from there and loaded into the result register.
// The phase machine and counters update once per item from the input register.
// arst_n clears the phase machine, counters and valids; config regs reset to defaults.
// out_stall holds the result register and, once the input register is full, in_stall.
module hopper_antijam_motor_sequencer_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  hams_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output hams_pkg::out_beat_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [hams_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [hams_pkg::CfgDataW-1:0]  cfg_data
);

	logic [6:0]        fwd_speed_q;
	logic signed [7:0] rev_speed_q;
	logic [15:0]       rev_ms_q;
	logic [15:0]       sample_ms_q;
	logic [15:0]       interval_ms_q;
	logic [8:0]        stall_deg_q;

	hams_pkg::phase_t                  phase_q, phase_d;
	logic [hams_pkg::TickW-1:0]        total_q, total_d, total_inc;
	logic [hams_pkg::TickW-1:0]        intv_q, intv_d, intv_inc;
	logic [hams_pkg::PhaseTickW-1:0]   pt_q, pt_d, pt_inc;
	logic signed [hams_pkg::SumW-1:0]  sum_q, sum_d, sum_sat;
	logic signed [hams_pkg::SumW:0]    sum_wide;
	logic signed [hams_pkg::SumW+1:0]  jam_test;
	logic [15:0]                       limit_q, limit_d;
	logic signed [7:0]                 drive_q, drive_d, drive_fwd;
	logic                              fin_d, jam_d;

	logic                valid_s1;
	hams_pkg::in_beat_t  data_s1;
	logic                adv;
	hams_pkg::out_beat_t out_q;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_speed_q   <= hams_pkg::FwdSpeedRst;
			rev_speed_q   <= hams_pkg::RevSpeedRst;
			rev_ms_q      <= hams_pkg::RevMsRst;
			sample_ms_q   <= hams_pkg::SampleMsRst;
			interval_ms_q <= hams_pkg::IntervalMsRst;
			stall_deg_q   <= hams_pkg::StallDegRst;
		end else if (cfg_valid && cfg_ready) begin
			case (hams_pkg::cfg_reg_t'(cfg_index))
				hams_pkg::REG_FORWARD_SPEED: fwd_speed_q   <= cfg_data[6:0];
				hams_pkg::REG_REVERSE_SPEED: rev_speed_q   <= $signed(cfg_data[7:0]);
				hams_pkg::REG_REVERSE_MS:    rev_ms_q      <= cfg_data;
				hams_pkg::REG_SAMPLE_MS:     sample_ms_q   <= cfg_data;
				hams_pkg::REG_INTERVAL_MS:   interval_ms_q <= cfg_data;
				hams_pkg::REG_STALL_DEGREES: stall_deg_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	assign total_inc = (&total_q) ? total_q : total_q + 1'b1;
	assign intv_inc  = (&intv_q) ? intv_q : intv_q + 1'b1;
	assign pt_inc    = (&pt_q) ? pt_q : pt_q + 1'b1;
	assign drive_fwd = 8'sd0 - $signed({1'b0, fwd_speed_q});

	always_comb begin
		sum_wide = {sum_q[hams_pkg::SumW-1], sum_q}
			+ {{(hams_pkg::SumW-7){data_s1.encoder_step[7]}}, data_s1.encoder_step};
		if (sum_wide[hams_pkg::SumW] != sum_wide[hams_pkg::SumW-1]) begin
			sum_sat = sum_wide[hams_pkg::SumW] ? {1'b1, {(hams_pkg::SumW-1){1'b0}}}
				: {1'b0, {(hams_pkg::SumW-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[hams_pkg::SumW-1:0];
		end
		jam_test = {{2{sum_sat[hams_pkg::SumW-1]}}, sum_sat}
			+ $signed({{(hams_pkg::SumW-7){1'b0}}, stall_deg_q});
	end

	always_comb begin
		phase_d = phase_q;
		total_d = total_q;
		intv_d  = intv_q;
		pt_d    = pt_q;
		sum_d   = sum_q;
		limit_d = limit_q;
		drive_d = drive_q;
		fin_d   = 1'b0;
		jam_d   = 1'b0;
		if (data_s1.operation == hams_pkg::OP_START) begin
			limit_d = data_s1.run_time_ms;
			total_d = '0;
			intv_d  = '0;
			if (data_s1.run_time_ms == '0) begin
				phase_d = hams_pkg::PH_IDLE;
				fin_d   = 1'b1;
			end else begin
				drive_d = drive_fwd;
				pt_d    = '0;
				if (interval_ms_q == '0) begin
					drive_d = rev_speed_q;
					phase_d = hams_pkg::PH_PERREV;
				end else begin
					phase_d = hams_pkg::PH_WINDOW;
					sum_d   = '0;
				end
			end
		end else if (phase_q != hams_pkg::PH_IDLE) begin
			total_d = total_inc;
			intv_d  = intv_inc;
			pt_d    = pt_inc;
			case (phase_q)
				hams_pkg::PH_WINDOW: begin
					sum_d = sum_sat;
					if (pt_inc >= sample_ms_q) begin
						if (jam_test > 0) begin
							jam_d   = 1'b1;
							drive_d = rev_speed_q;
							phase_d = hams_pkg::PH_JAMREV;
							pt_d    = '0;
						end else begin
							phase_d = hams_pkg::PH_WINDOW;
						end
					end
				end
				hams_pkg::PH_JAMREV: begin
					if (pt_inc >= rev_ms_q) begin
						phase_d = hams_pkg::PH_WINDOW;
					end
				end
				hams_pkg::PH_PERREV: begin
					if (pt_inc >= rev_ms_q) begin
						if (total_inc >= {1'b0, limit_q}) begin
							phase_d = hams_pkg::PH_IDLE;
							fin_d   = 1'b1;
						end else begin
							phase_d = hams_pkg::PH_WINDOW;
						end
					end
				end
				default: ;
			endcase
			// forward test point: periodic reversal or a fresh window
			if (phase_d == hams_pkg::PH_WINDOW && phase_d != phase_q
					|| phase_q == hams_pkg::PH_WINDOW && phase_d == hams_pkg::PH_WINDOW
					&& pt_inc >= sample_ms_q) begin
				drive_d = drive_fwd;
				pt_d    = '0;
				if (intv_inc >= {1'b0, interval_ms_q}) begin
					intv_d  = '0;
					drive_d = rev_speed_q;
					phase_d = hams_pkg::PH_PERREV;
				end else begin
					sum_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hams_pkg::PH_IDLE;
			total_q <= '0;
			intv_q  <= '0;
			pt_q    <= '0;
			sum_q   <= '0;
			limit_q <= '0;
			drive_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			total_q <= total_d;
			intv_q  <= intv_d;
			pt_q    <= pt_d;
			sum_q   <= sum_d;
			limit_q <= limit_d;
			drive_q <= drive_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.motor_drive <= drive_d;
			out_q.busy_res    <= (phase_d != hams_pkg::PH_IDLE);
			out_q.finished    <= fin_d;
			out_q.jam_seen    <= jam_d;
		end
	end

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked item");

	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_q.busy_res == (phase_q != hams_pkg::PH_IDLE)
			&& out_q.motor_drive == drive_q)
		else $error("result does not match state");

	a_jam_reverses: assert property (@(posedge clk) disable iff (!arst_n)
		adv && jam_d |=> phase_q == hams_pkg::PH_JAMREV && drive_q == rev_speed_q)
		else $error("jam without reversal");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fin_d |=> phase_q == hams_pkg::PH_IDLE && !out_q.busy_res)
		else $error("finished while still busy");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam logic [hams_pkg::TickW-1:0] CntMax = '1;
	localparam int SumMax = 8388607;
	localparam int SumMin = -8388608;
	localparam int QuietLimit = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	hams_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	hams_pkg::out_beat_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hams_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [hams_pkg::CfgDataW-1:0] cfg_data = '0;

	hopper_antijam_motor_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// register copies
	logic [6:0] fwd_speed = hams_pkg::FwdSpeedRst;
	logic signed [7:0] rev_speed = hams_pkg::RevSpeedRst;
	logic [15:0] rev_ms = hams_pkg::RevMsRst;
	logic [15:0] sample_ms = hams_pkg::SampleMsRst;
	logic [15:0] interval_ms = hams_pkg::IntervalMsRst;
	logic [8:0] stall_deg = hams_pkg::StallDegRst;

	// sequencer state
	hams_pkg::phase_t run_phase = hams_pkg::PH_IDLE;
	logic [hams_pkg::TickW-1:0] total_el = '0;
	logic [hams_pkg::TickW-1:0] interval_el = '0;
	logic [hams_pkg::PhaseTickW-1:0] phase_ticks = '0;
	logic signed [hams_pkg::SumW-1:0] window_sum = '0;
	logic [15:0] run_limit = '0;
	logic signed [7:0] drive_now = '0;

	hams_pkg::in_beat_t queued_cmds[$];
	hams_pkg::out_beat_t expected_status[$];
	int pushed = 0;
	int accepted = 0;
	int results_seen = 0;
	int errors = 0;
	int in_gap = 0;
	int in_calm = 0;
	int out_gap = 0;
	int out_calm = 0;
	int quiet_cycles = 0;

	function automatic logic [15:0] floor_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic void go_forward();
		drive_now = -$signed({1'b0, fwd_speed});
		if (interval_el >= interval_ms) begin
			interval_el = '0;
			drive_now = rev_speed;
			run_phase = hams_pkg::PH_PERREV;
			phase_ticks = '0;
		end else begin
			run_phase = hams_pkg::PH_WINDOW;
			phase_ticks = '0;
			window_sum = '0;
		end
	endfunction

	task automatic step_sequencer(input hams_pkg::in_beat_t b);
		hams_pkg::out_beat_t r;
		int s;
		r = '0;
		if (b.operation == hams_pkg::OP_START) begin
			run_limit = b.run_time_ms;
			total_el = '0;
			interval_el = '0;
			if (run_limit == 16'd0) begin
				run_phase = hams_pkg::PH_IDLE;
				r.finished = 1'b1;
			end else begin
				go_forward();
			end
		end else if (run_phase != hams_pkg::PH_IDLE) begin
			if (total_el != CntMax) total_el++;
			if (interval_el != CntMax) interval_el++;
			if (phase_ticks != '1) phase_ticks++;
			case (run_phase)
				hams_pkg::PH_WINDOW: begin
					s = int'(window_sum) + int'(b.encoder_step);
					if (s > SumMax) s = SumMax;
					if (s < SumMin) s = SumMin;
					window_sum = s[hams_pkg::SumW-1:0];
					if (phase_ticks >= floor_one(sample_ms)) begin
						if (int'(window_sum) > -int'(stall_deg)) begin
							r.jam_seen = 1'b1;
							drive_now = rev_speed;
							run_phase = hams_pkg::PH_JAMREV;
							phase_ticks = '0;
						end else begin
							go_forward();
						end
					end
				end
				hams_pkg::PH_JAMREV: begin
					if (phase_ticks >= floor_one(rev_ms)) go_forward();
				end
				default: begin
					if (phase_ticks >= floor_one(rev_ms)) begin
						if (total_el >= run_limit) begin
							run_phase = hams_pkg::PH_IDLE;
							r.finished = 1'b1;
						end else begin
							go_forward();
						end
					end
				end
			endcase
		end
		r.motor_drive = drive_now;
		r.busy_res = (run_phase != hams_pkg::PH_IDLE);
		expected_status.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic check_status(input hams_pkg::out_beat_t got);
		hams_pkg::out_beat_t want;
		results_seen++;
		if (expected_status.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
			return;
		end
		want = expected_status.pop_front();
		if (got.motor_drive !== want.motor_drive)
			report_mismatch($sformatf("result %0d motor_drive %0d, expected %0d",
				results_seen, got.motor_drive, want.motor_drive));
		if (got.busy_res !== want.busy_res)
			report_mismatch($sformatf("result %0d busy_res %b, expected %b",
				results_seen, got.busy_res, want.busy_res));
		if (got.finished !== want.finished)
			report_mismatch($sformatf("result %0d finished %b, expected %b",
				results_seen, got.finished, want.finished));
		if (got.jam_seen !== want.jam_seen)
			report_mismatch($sformatf("result %0d jam_seen %b, expected %b",
				results_seen, got.jam_seen, want.jam_seen));
	endtask

	// wait before next beat; runs of zero waits now and then
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 30);
		return $urandom_range(0, 19);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				step_sequencer(in_data);
				accepted++;
				in_gap = draw_wait(in_calm);
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (queued_cmds.size() != 0) begin
					in_data <= queued_cmds.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_status(out_data);
				out_gap = draw_wait(out_calm);
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input hams_pkg::cfg_reg_t idx, input int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hams_pkg::REG_FORWARD_SPEED: fwd_speed = val[6:0];
			hams_pkg::REG_REVERSE_SPEED: rev_speed = val[7:0];
			hams_pkg::REG_REVERSE_MS: rev_ms = val[15:0];
			hams_pkg::REG_SAMPLE_MS: sample_ms = val[15:0];
			hams_pkg::REG_INTERVAL_MS: interval_ms = val[15:0];
			hams_pkg::REG_STALL_DEGREES: stall_deg = val[8:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int fwd, input int rev, input int rms, input int sms,
			input int ims, input int stall);
		write_reg(hams_pkg::REG_FORWARD_SPEED, fwd);
		write_reg(hams_pkg::REG_REVERSE_SPEED, rev);
		write_reg(hams_pkg::REG_REVERSE_MS, rms);
		write_reg(hams_pkg::REG_SAMPLE_MS, sms);
		write_reg(hams_pkg::REG_INTERVAL_MS, ims);
		write_reg(hams_pkg::REG_STALL_DEGREES, stall);
	endtask

	task automatic push_item(input hams_pkg::op_t op, input int run, input int step);
		hams_pkg::in_beat_t c;
		c.operation = op;
		c.run_time_ms = run[15:0];
		c.encoder_step = step[7:0];
		do @(negedge clk); while (queued_cmds.size() != 0);
		queued_cmds.push_back(c);
		pushed++;
	endtask

	task automatic tick(input int step);
		push_item(hams_pkg::OP_TICK, $urandom_range(0, 65535), step);
	endtask

	function automatic int next_step(input int travel);
		int v;
		if ($urandom_range(0, 9) == 0) begin
			v = $urandom_range(0, 255);
			return v - 128;
		end
		v = int'($urandom_range(0, 20)) - 10 - travel;
		return (v < -128) ? -128 : v;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (queued_cmds.size() != 0 || in_valid || expected_status.size() != 0);
	endtask

	// end any run still going with a zero-length start
	task automatic settle_idle();
		wait_drained();
		if (run_phase != hams_pkg::PH_IDLE) begin
			push_item(hams_pkg::OP_START, 0, $urandom_range(0, 255));
			wait_drained();
		end
	endtask

	task automatic drive_run(input int run_len, input int cap);
		int start_seq;
		int travel;
		int n;
		push_item(hams_pkg::OP_START, run_len, $urandom_range(0, 255));
		start_seq = pushed;
		travel = $urandom_range(0, 80);
		n = 0;
		while ((accepted < start_seq || run_phase != hams_pkg::PH_IDLE) && n < cap) begin
			if ($urandom_range(0, 7) == 0) travel = $urandom_range(0, 80);
			if ($urandom_range(0, 60) == 0)
				push_item(hams_pkg::OP_START, $urandom_range(0, 65535),
					$urandom_range(0, 255));
			else
				tick(next_step(travel));
			n++;
		end
	endtask

	task automatic run_phase_items(input int n);
		int stop;
		int len;
		stop = pushed + n;
		while (pushed < stop) begin
			if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 65535);
			else len = $urandom_range(1, 60);
			drive_run(len, stop - pushed);
		end
		settle_idle();
	endtask

	initial begin
		int sms;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle ticks, zero run, restart while busy
		tick(127);
		tick(-128);
		push_item(hams_pkg::OP_START, 0, 0);
		push_item(hams_pkg::OP_START, 16'hFFFF, -1);
		tick(-40);
		tick(-40);
		push_item(hams_pkg::OP_START, 16'h8000, 127);
		tick(5);
		settle_idle();

		// short windows: clean, jam, reversals, finish
		configure(100, -100, 2, 2, 3, 10);
		push_item(hams_pkg::OP_START, 9, 0);
		tick(-20);
		tick(-20);
		tick(0);
		tick(0);
		tick(3);
		tick(-3);
		tick(-60);
		tick(-60);
		tick(-60);
		tick(-60);
		tick(10);
		tick(-10);
		tick(-100);
		tick(-100);
		settle_idle();

		configure(1, 100, 0, 0, 0, 0);
		run_phase_items(60);
		configure(100, -100, 1, 1, 1, 360);
		run_phase_items(60);
		configure(50, 0, 65535, 3, 65535, 360);
		run_phase_items(30);
		configure(37, -1, 3, 65535, 2, 0);
		run_phase_items(30);
		repeat (9) begin
			sms = $urandom_range(1, 8);
			configure($urandom_range(1, 100), int'($urandom_range(0, 200)) - 100,
				$urandom_range(1, 6), sms, $urandom_range(1, 40),
				$urandom_range(0, (sms * 50 > 360) ? 360 : sms * 50));
			run_phase_items(95);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
